// File: design/gda_pkg.sv
// ----------------------------------------------------------------------------
// gda_pkg: shared types and constants of the date add days unit
// Transfer structs, calendar constants, month length lookup and the
// control and status structs between the sequencer, the adder and the
// calendar tracker.
// ----------------------------------------------------------------------------
package gda_pkg;

   // field widths
   localparam int DAY_W    = 5;
   localparam int MONTH_W  = 4;
   localparam int YEAR_W   = 14;
   localparam int ADD_W    = 15;
   // running day count: max day of year plus 31 plus the largest add
   localparam int REMAIN_W = 16;
   // running year: start year plus the years walked, never wraps
   localparam int YEAR_RUN_W = 15;

   // calendar constants
   localparam int YEAR_CYCLE  = 400;
   localparam int CENTURY     = 100;
   localparam int MOD_STEPS   = 6;   // quotient of year / 400 fits 6 bits
   localparam int STEP_W      = 3;
   localparam logic [MONTH_W-1:0] FIRST_MONTH = MONTH_W'(1);
   localparam logic [MONTH_W-1:0] LAST_MONTH  = MONTH_W'(12);
   localparam logic [DAY_W-1:0]   FEB_LEAP    = DAY_W'(29);
   localparam logic [DAY_W-1:0]   FEB_COMMON  = DAY_W'(28);

   localparam logic [DAY_W-1:0] MONTH_LEN_TAB [0:12] = '{
      DAY_W'(0),  DAY_W'(31), DAY_W'(28), DAY_W'(31), DAY_W'(30),
      DAY_W'(31), DAY_W'(30), DAY_W'(31), DAY_W'(31), DAY_W'(30),
      DAY_W'(31), DAY_W'(30), DAY_W'(31)
   };

   // input and result transfers
   typedef struct packed {
      logic [DAY_W-1:0]   start_day;
      logic [MONTH_W-1:0] start_month;
      logic [YEAR_W-1:0]  start_year;
      logic [ADD_W-1:0]   days_to_add;
   } req_type;

   typedef struct packed {
      logic [DAY_W-1:0]   result_day;
      logic [MONTH_W-1:0] result_month;
      logic [YEAR_W-1:0]  result_year;
   } rsp_type;

   // shared adder request and status
   typedef struct packed {
      logic                sub;
      logic [REMAIN_W-1:0] opa;
      logic [REMAIN_W-1:0] opb;
   } alu_req_type;

   typedef struct packed {
      logic [REMAIN_W-1:0] result;
      logic                borrow;
      logic                zero;
   } alu_rsp_type;

   // calendar tracker controls
   typedef struct packed {
      logic load;       // take the start year
      logic reduce;     // keep the adder difference as year remainder
      logic next_year;  // step to january of the next year
   } cal_ctrl_type;

   // month length, zero outside january..december
   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
      logic [DAY_W-1:0] len;
      if (month < FIRST_MONTH || month > LAST_MONTH) begin
         len = '0;
      end else if (month == MONTH_W'(2)) begin
         len = leap ? FEB_LEAP : FEB_COMMON;
      end else begin
         len = MONTH_LEN_TAB[month];
      end
      return len;
   endfunction

endpackage

// File: design/gda_alu.sv
// ----------------------------------------------------------------------------
// gda_alu: shared add / subtract and compare unit
// One carry chain used for the start sum, the year reduction, the month
// sums and the month walk. Flags borrow and zero for the compares.
// ----------------------------------------------------------------------------
module gda_alu (
   input  gda_pkg::alu_req_type alu_req,
   output gda_pkg::alu_rsp_type alu_rsp
);
   import gda_pkg::*;

   logic [REMAIN_W-1:0] opb_eff;
   logic [REMAIN_W:0]   sum_w;

   // subtract as add of the complement plus one
   always_comb begin
      opb_eff = alu_req.sub ? ~alu_req.opb : alu_req.opb;
      sum_w   = {1'b0, alu_req.opa} + {1'b0, opb_eff} + {{REMAIN_W{1'b0}}, alu_req.sub};
   end

   assign alu_rsp.result = sum_w[REMAIN_W-1:0];
   assign alu_rsp.borrow = alu_req.sub & ~sum_w[REMAIN_W];
   assign alu_rsp.zero   = (sum_w[REMAIN_W-1:0] == '0);

endmodule

// File: design/gda_calendar.sv
// ----------------------------------------------------------------------------
// gda_calendar: running year and leap tracking
// Holds the running year and its remainder modulo 400, gives the length
// of the month being visited and steps the year at each december rollover.
// ----------------------------------------------------------------------------
module gda_calendar (
   input  logic                              clock,
   input  gda_pkg::cal_ctrl_type             cal_ctrl,
   input  logic [gda_pkg::YEAR_W-1:0]        start_year,
   input  logic [gda_pkg::REMAIN_W-1:0]      reduce_value,
   input  logic [gda_pkg::MONTH_W-1:0]       month,
   output logic [gda_pkg::YEAR_W-1:0]        year_rem,
   output logic [gda_pkg::YEAR_RUN_W-1:0]    year_run,
   output logic [gda_pkg::DAY_W-1:0]         month_len
);
   import gda_pkg::*;

   logic [YEAR_RUN_W-1:0] year_ff, year_in;
   logic [YEAR_W-1:0]     yrem_ff, yrem_in;
   logic                  leap;

   // year and remainder next values
   always_comb begin
      year_in = year_ff;
      yrem_in = yrem_ff;
      if (cal_ctrl.load) begin
         year_in = YEAR_RUN_W'(start_year);
         yrem_in = start_year;
      end else if (cal_ctrl.reduce) begin
         yrem_in = reduce_value[YEAR_W-1:0];
      end else if (cal_ctrl.next_year) begin
         year_in = year_ff + YEAR_RUN_W'(1);
         yrem_in = (yrem_ff == YEAR_W'(YEAR_CYCLE - 1)) ? '0 : yrem_ff + YEAR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      year_ff <= year_in;
      yrem_ff <= yrem_in;
   end

   // leap: divisible by 4 and not a century, or divisible by 400
   assign leap = (yrem_ff[1:0] == 2'b00) &&
                 (yrem_ff != YEAR_W'(CENTURY)) &&
                 (yrem_ff != YEAR_W'(2 * CENTURY)) &&
                 (yrem_ff != YEAR_W'(3 * CENTURY));

   assign month_len = month_days(month, leap);
   assign year_rem  = yrem_ff;
   assign year_run  = year_ff;

endmodule

// File: design/gregorian_date_add_days_unit.sv
// ----------------------------------------------------------------------------
// gregorian_date_add_days_unit: gregorian date plus a count of days
// Sequencer around one shared adder that forms the day of the year and then
// walks month by month to the resulting date.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// until the result is shown. The result appears on rsp_data for exactly one
// cycle with rsp_valid high and must be captured then: there is no way to
// hold it off. The single shared adder first adds the day count to the start
// day and reduces the year modulo 400 for the leap test, then sums the
// months before the start month and walks month by month from january of
// the start year, handling one month per cycle. A new item may be started
// in the cycle of the strobe.
// ----------------------------------------------------------------------------
module gregorian_date_add_days_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  gda_pkg::req_type  req_data,
   output logic              rsp_valid,
   output gda_pkg::rsp_type  rsp_data
);
   import gda_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_INIT = 5'b00010,
      ST_MOD  = 5'b00100,
      ST_SUM  = 5'b01000,
      ST_WALK = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [REMAIN_W-1:0]   remain_ff, remain_in;
   logic [ADD_W-1:0]      add_ff, add_in;
   logic [MONTH_W-1:0]    month_ff, month_in;
   logic [MONTH_W-1:0]    m_ff, m_in;
   logic [STEP_W-1:0]     k_ff, k_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   alu_req_type           alu_req;
   alu_rsp_type           alu_rsp;
   cal_ctrl_type          cal_ctrl;
   logic [YEAR_W-1:0]     year_rem;
   logic [YEAR_RUN_W-1:0] year_run;
   logic [DAY_W-1:0]      month_len;
   logic                  accept;
   logic                  walk_more;

   assign accept = start && (state_ff == ST_IDLE);

   gda_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   gda_calendar u_calendar (
      .clock        (clock),
      .cal_ctrl     (cal_ctrl),
      .start_year   (req_data.start_year),
      .reduce_value (alu_rsp.result),
      .month        (m_ff),
      .year_rem     (year_rem),
      .year_run     (year_run),
      .month_len    (month_len)
   );

   // shared adder operand select
   always_comb begin
      alu_req.sub = 1'b0;
      alu_req.opa = remain_ff;
      alu_req.opb = REMAIN_W'(month_len);
      case (state_ff)
         ST_INIT: begin
            alu_req.opb = REMAIN_W'(add_ff);
         end
         ST_MOD: begin
            alu_req.sub = 1'b1;
            alu_req.opa = REMAIN_W'(year_rem);
            alu_req.opb = REMAIN_W'(YEAR_CYCLE) << k_ff;
         end
         ST_WALK: begin
            alu_req.sub = 1'b1;
         end
         default: begin
            alu_req.sub = 1'b0;
         end
      endcase
   end

   // remaining count strictly above the month length
   assign walk_more = !alu_rsp.borrow && !alu_rsp.zero;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      remain_in    = remain_ff;
      add_in       = add_ff;
      month_in     = month_ff;
      m_in         = m_ff;
      k_in         = k_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      cal_ctrl     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               remain_in     = REMAIN_W'(req_data.start_day);
               add_in        = req_data.days_to_add;
               month_in      = req_data.start_month;
               cal_ctrl.load = 1'b1;
               state_in      = ST_INIT;
            end
         end
         ST_INIT: begin
            remain_in = alu_rsp.result;
            k_in      = STEP_W'(MOD_STEPS - 1);
            state_in  = ST_MOD;
         end
         ST_MOD: begin
            // restoring reduction of the year modulo 400
            cal_ctrl.reduce = !alu_rsp.borrow;
            k_in = k_ff - STEP_W'(1);
            if (k_ff == '0) begin
               m_in     = FIRST_MONTH;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            // add the months before the start month
            if (m_ff < month_ff && m_ff <= LAST_MONTH) begin
               remain_in = alu_rsp.result;
               m_in      = m_ff + MONTH_W'(1);
            end else begin
               m_in     = FIRST_MONTH;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (walk_more) begin
               remain_in = alu_rsp.result;
               if (m_ff == LAST_MONTH) begin
                  m_in               = FIRST_MONTH;
                  cal_ctrl.next_year = 1'b1;
               end else begin
                  m_in = m_ff + MONTH_W'(1);
               end
            end else begin
               rsp_in.result_day   = remain_ff[DAY_W-1:0];
               rsp_in.result_month = m_ff;
               rsp_in.result_year  = year_run[YEAR_W-1:0];
               rsp_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      remain_ff <= remain_in;
      add_ff    <= add_in;
      month_ff  <= month_in;
      m_ff      <= m_in;
      k_ff      <= k_in;
      rsp_ff    <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // a transfer always starts work
   assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("transfer did not start work");

   // a result only comes out of the month walk
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_WALK))
      else $error("result strobe without a finished walk");

   // the strobe lasts a single cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // the walk only visits real months
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (m_ff >= FIRST_MONTH && m_ff <= LAST_MONTH))
      else $error("month counter out of range during walk");

   // year reduction leaves a remainder below 400
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM) |-> (year_rem < YEAR_W'(YEAR_CYCLE)))
      else $error("year remainder not reduced");
`endif

endmodule
